// ===== sv/dda_pkg.sv =====
// Shared types, codes and sizes of the DDA step generator.
`default_nettype none

package dda_pkg;

  localparam int AXES = 3;
  localparam int STEP_BITS = 24;
  localparam int TICK_BITS = 28;
  localparam int VIS_AXES = (AXES < 3) ? AXES : 3;
  localparam int ACC_BITS = 42;
  localparam int QDEPTH = 2;
  localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef logic signed [ACC_BITS-1:0] acc_t;
  localparam acc_t ACC_LIMIT = ACC_BITS'(64'h100_0000_0000);

  typedef enum logic [1:0] {
    ACT_SET,
    ACT_START,
    ACT_TICK,
    ACT_ABORT
  } action_t;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_REV = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_ABORTED = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic [1:0] CLEAR_MINUS = 2'h1;
  localparam logic [1:0] CLEAR_PLUS = 2'h2;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  axis;
    logic [23:0] step_count;
    logic [1:0]  direction;
    logic [27:0] total_ticks;
    logic [5:0]  endstop_bits;
  } req_t;

  typedef struct packed {
    logic [2:0]  step_toggle;
    logic [2:0]  reverse_mask;
    logic        moving;
    logic        move_done;
    logic [1:0]  status;
    logic [23:0] steps_left;
  } rsp_t;

  typedef struct packed {
    action_t               kind;
    logic [1:0]            axis;
    logic                  set_ok;
    logic [1:0]            dir;
    logic [STEP_BITS-1:0]  count;
    logic [TICK_BITS-1:0]  ticks;
    logic [AXES-1:0]       clear_fwd;
    logic [AXES-1:0]       clear_rev;
  } cmd_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QCNT_BITS-1:0] count;
  } q_status_t;

endpackage

`default_nettype wire

// ===== sv/multi_axis_dda_step_generator_top.sv =====
// Top level of the three-axis DDA step generator.
// Requests enter on cmd (cmd_valid / cmd_ready) as set_axis, start, tick or
// abort items; each request yields exactly one result on rsp (rsp_valid /
// rsp_ready) carrying step toggles, direction mask, moving, done, status and
// the remaining steps of the addressed axis.
// An accepted request is stored in the command queue, and its result is then
// registered in the result register. One request per cycle is sustained while
// rsp_ready stays high; every active axis updates its accumulator in parallel.
// A two-entry command queue separates the decoder from the motion engine.
// When the receiver stalls, the result register holds its value, the queue
// fills, and cmd_ready drops once both queue entries are taken.
// Synchronous reset clears all axis counts, directions and accumulators,
// stops any move and empties the queue; no request is taken during reset.
`default_nettype none

module multi_axis_dda_step_generator_top
  import dda_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire req_t cmd,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  q_status_t q_stat;
  logic      push;
  logic      pop;
  cmd_t      dec_cmd;
  cmd_t      head;

  dda_front u_front (
    .rst       (rst),
    .req_valid (cmd_valid),
    .req_ready (cmd_ready),
    .req       (cmd),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (dec_cmd)
  );

  dda_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (dec_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  dda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_BITS'(QDEPTH))
    else $error("Command queue holds more entries than it has.");

  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.move_done |-> !rsp.moving && rsp.step_toggle == 3'd0)
    else $error("A completing tick reports motion.");

  a_step_moving: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.step_toggle != 3'd0 |-> rsp.moving && rsp.status == ST_OK)
    else $error("Step toggles reported outside a running move.");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> q_stat.count == $past(q_stat.count) - 1'b1)
    else $error("Queue level does not follow a pop.");
`endif

endmodule

`default_nettype wire

// ===== sv/dda_front.sv =====
// Front end: accepts requests and decodes them into queued commands.
`default_nettype none

module dda_front
  import dda_pkg::*;
(
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire req_t      req,
  input  wire q_status_t q_stat,
  output logic           push,
  output cmd_t           cmd
);

  logic [1:0] side;

  assign req_ready = !rst && !q_stat.full;
  assign push = req_valid && req_ready;

  always_comb begin
    side = '0;
    cmd.kind = action_t'(req.action);
    cmd.axis = req.axis;
    cmd.dir = req.direction;
    cmd.set_ok = (int'(req.axis) < AXES) && (req.direction != 2'd3);
    cmd.count = (req.direction == DIR_NONE) ? '0 : STEP_BITS'(req.step_count);
    cmd.ticks = TICK_BITS'(req.total_ticks);
    for (int i = 0; i < AXES; i++) begin
      side = 2'(req.endstop_bits >> (2 * i));
      if (i >= 3) begin
        cmd.clear_fwd[i] = 1'b1;
        cmd.clear_rev[i] = 1'b1;
      end else begin
        cmd.clear_fwd[i] = (side & CLEAR_PLUS) != '0;
        cmd.clear_rev[i] = (side & CLEAR_MINUS) != '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/dda_queue.sv =====
// Short command queue between the front end and the motion engine.
`default_nettype none

module dda_queue
  import dda_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output q_status_t q_stat
);

  cmd_t                 slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign head = slots[rd_ptr];
  assign q_stat.count = count;
  assign q_stat.full = (count == QCNT_BITS'(QDEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dda_back.sv =====
// Motion engine: axis state, Bresenham update and the result register.
`default_nettype none

module dda_back
  import dda_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cmd_t      head,
  input  wire q_status_t q_stat,
  output logic           pop,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output rsp_t           rsp
);

  logic [STEP_BITS-1:0] prog [AXES];
  logic [STEP_BITS-1:0] rem [AXES];
  logic [1:0]           dirs [AXES];
  acc_t                 acc [AXES];
  logic [TICK_BITS-1:0] move_ticks;
  logic                 running;

  logic [STEP_BITS-1:0] prog_next [AXES];
  logic [STEP_BITS-1:0] rem_next [AXES];
  logic [1:0]           dirs_next [AXES];
  acc_t                 acc_next [AXES];
  logic [TICK_BITS-1:0] move_ticks_next;
  logic                 running_next;
  rsp_t                 rsp_next;

  acc_t            sum [AXES];
  acc_t            over [AXES];
  acc_t            t_one;
  acc_t            t_two;
  logic [AXES-1:0] hit;
  logic            any;
  logic            blocked;
  logic [1:0]      status;

  assign pop = !q_stat.empty && (!rsp_valid || rsp_ready);
  assign t_one = acc_t'(move_ticks);
  assign t_two = acc_t'({move_ticks, 1'b0});

  always_comb begin
    prog_next = prog;
    rem_next = rem;
    dirs_next = dirs;
    acc_next = acc;
    move_ticks_next = move_ticks;
    running_next = running;
    hit = '0;
    any = 1'b0;
    blocked = 1'b0;
    status = ST_OK;
    rsp_next = '0;

    for (int i = 0; i < AXES; i++) begin
      sum[i] = acc[i] + acc_t'({prog[i], 1'b0});
      over[i] = sum[i] - t_two;
      if ((dirs[i] == DIR_FWD && !head.clear_fwd[i]) ||
          (dirs[i] == DIR_REV && !head.clear_rev[i])) begin
        blocked = 1'b1;
      end
    end

    case (head.kind)
      ACT_SET: begin
        if (running || !head.set_ok) begin
          status = ST_IGNORED;
        end else begin
          for (int i = 0; i < AXES; i++) begin
            if (int'(head.axis) == i) begin
              prog_next[i] = head.count;
              rem_next[i] = head.count;
              dirs_next[i] = head.dir;
              acc_next[i] = '0;
            end
          end
        end
      end
      ACT_START: begin
        if (running) begin
          status = ST_IGNORED;
        end else if (blocked) begin
          status = ST_BLOCKED;
        end else begin
          move_ticks_next = head.ticks;
          running_next = 1'b1;
        end
      end
      ACT_TICK: begin
        if (!running) begin
          status = ST_IGNORED;
        end else begin
          for (int i = 0; i < AXES; i++) begin
            if (dirs[i] != DIR_NONE && rem[i] != '0) begin
              any = 1'b1;
              if (sum[i] > t_one) begin
                hit[i] = 1'b1;
                rem_next[i] = rem[i] - 1'b1;
                acc_next[i] = (over[i] > ACC_LIMIT) ? ACC_LIMIT : over[i];
              end else begin
                acc_next[i] = (sum[i] > ACC_LIMIT) ? ACC_LIMIT : sum[i];
              end
            end
          end
          if (!any) begin
            running_next = 1'b0;
            rsp_next.move_done = 1'b1;
          end
        end
      end
      ACT_ABORT: begin
        if (running) begin
          running_next = 1'b0;
          status = ST_ABORTED;
        end else begin
          status = ST_IGNORED;
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase

    for (int j = 0; j < VIS_AXES; j++) begin
      rsp_next.step_toggle[j] = hit[j];
      rsp_next.reverse_mask[j] = (dirs_next[j] == DIR_REV);
    end
    for (int i = 0; i < AXES; i++) begin
      if (int'(head.axis) == i) begin
        rsp_next.steps_left = 24'(rem_next[i]);
      end
    end
    rsp_next.moving = running_next;
    rsp_next.status = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        prog[i] <= '0;
        rem[i] <= '0;
        dirs[i] <= DIR_NONE;
        acc[i] <= '0;
      end
      move_ticks <= '0;
      running <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (pop) begin
        prog <= prog_next;
        rem <= rem_next;
        dirs <= dirs_next;
        acc <= acc_next;
        move_ticks <= move_ticks_next;
        running <= running_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
